@@ src/slipdx_pkg.sv @@
// Package for the SLIP deframer with nibble XOR check.
// Holds the framing byte codes, the result kind codes and the result types.
// No dependencies.
package slipdx_pkg;

    localparam logic [7:0] FLAG_BYTE = 8'hC0;
    localparam logic [7:0] ESC_BYTE  = 8'hDB;
    localparam logic [7:0] ESC_FLAG  = 8'hDC;
    localparam logic [7:0] ESC_ESC   = 8'hDD;

    typedef enum logic [1:0] {
        KIND_PAYLOAD  = 2'd0,
        KIND_END_GOOD = 2'd1,
        KIND_END_BAD  = 2'd2
    } kind_t;

    typedef struct packed {
        logic [7:0] out_byte;
        kind_t      out_kind;
        logic       last_of_run;
    } result_t;

    typedef struct packed {
        logic [1:0] cnt;
        result_t    r0;
        result_t    r1;
    } emit_t;

endpackage

@@ src/slipdx_deframer.sv @@
// Frame state and per-byte decode for the SLIP deframer.
// Produces zero, one or two results per accepted byte. Uses slipdx_pkg.
module slipdx_deframer (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                accept,
    input  logic [7:0]          line_byte,
    output slipdx_pkg::emit_t   emit
);
    import slipdx_pkg::*;

    logic       in_frame_reg, in_frame_next;
    logic [1:0] raw_count_reg, raw_count_next;
    logic [7:0] delay0_reg, delay0_next;
    logic [7:0] delay1_reg, delay1_next;
    logic [7:0] xor_sum_reg, xor_sum_next;
    logic       esc_reg, esc_next;
    logic       payload_seen_reg, payload_seen_next;

    logic [7:0] got;
    logic       good;
    kind_t      end_kind;
    logic [1:0] n;
    result_t    r0, r1;

    assign got      = {delay0_reg[3:0], 4'b0000} + delay1_reg;
    assign good     = (got == xor_sum_reg);
    assign end_kind = good ? KIND_END_GOOD : KIND_END_BAD;

    always_comb begin
        in_frame_next     = in_frame_reg;
        raw_count_next    = raw_count_reg;
        delay0_next       = delay0_reg;
        delay1_next       = delay1_reg;
        xor_sum_next      = xor_sum_reg;
        esc_next          = esc_reg;
        payload_seen_next = payload_seen_reg;
        n                 = 2'd0;
        r0                = '{out_byte: 8'h00, out_kind: KIND_PAYLOAD, last_of_run: 1'b0};
        r1                = '{out_byte: 8'h00, out_kind: KIND_PAYLOAD, last_of_run: 1'b0};

        if (accept) begin
            if (!in_frame_reg) begin
                if (line_byte == FLAG_BYTE) begin
                    in_frame_next     = 1'b1;
                    raw_count_next    = 2'd0;
                    delay0_next       = 8'h00;
                    delay1_next       = 8'h00;
                    xor_sum_next      = 8'h00;
                    esc_next          = 1'b0;
                    payload_seen_next = 1'b0;
                end
            end else if (line_byte == FLAG_BYTE) begin
                if (raw_count_reg == 2'd2) begin
                    if (esc_reg) begin
                        r0.out_byte = ESC_BYTE;
                        r1.out_kind = end_kind;
                        n           = 2'd2;
                    end else if (payload_seen_reg) begin
                        r0.out_kind = end_kind;
                        n           = 2'd1;
                    end
                end
                // A lone flag after an empty frame restarts it; otherwise hunt again.
                in_frame_next     = (raw_count_reg == 2'd0);
                raw_count_next    = 2'd0;
                delay0_next       = 8'h00;
                delay1_next       = 8'h00;
                xor_sum_next      = 8'h00;
                esc_next          = 1'b0;
                payload_seen_next = 1'b0;
            end else if (raw_count_reg != 2'd2) begin
                if (raw_count_reg[0]) begin
                    delay1_next = line_byte;
                end else begin
                    delay0_next = line_byte;
                end
                raw_count_next = raw_count_reg + 2'd1;
            end else begin
                delay0_next  = delay1_reg;
                delay1_next  = line_byte;
                xor_sum_next = xor_sum_reg ^ delay0_reg;
                if (esc_reg) begin
                    if (delay0_reg == ESC_FLAG) begin
                        r0.out_byte = FLAG_BYTE;
                        n           = 2'd1;
                        esc_next    = 1'b0;
                    end else if (delay0_reg == ESC_ESC) begin
                        r0.out_byte = ESC_BYTE;
                        n           = 2'd1;
                        esc_next    = 1'b0;
                    end else if (delay0_reg == ESC_BYTE) begin
                        r0.out_byte = ESC_BYTE;
                        n           = 2'd1;
                    end else begin
                        r0.out_byte = ESC_BYTE;
                        r1.out_byte = delay0_reg;
                        n           = 2'd2;
                        esc_next    = 1'b0;
                    end
                end else if (delay0_reg == ESC_BYTE) begin
                    esc_next = 1'b1;
                end else begin
                    r0.out_byte = delay0_reg;
                    n           = 2'd1;
                end
                if (n != 2'd0) begin
                    payload_seen_next = 1'b1;
                end
            end
        end

        r0.last_of_run = (n == 2'd1);
        r1.last_of_run = (n == 2'd2);
    end

    assign emit = '{cnt: n, r0: r0, r1: r1};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_frame_reg     <= 1'b0;
            raw_count_reg    <= 2'd0;
            delay0_reg       <= 8'h00;
            delay1_reg       <= 8'h00;
            xor_sum_reg      <= 8'h00;
            esc_reg          <= 1'b0;
            payload_seen_reg <= 1'b0;
        end else begin
            in_frame_reg     <= in_frame_next;
            raw_count_reg    <= raw_count_next;
            delay0_reg       <= delay0_next;
            delay1_reg       <= delay1_next;
            xor_sum_reg      <= xor_sum_next;
            esc_reg          <= esc_next;
            payload_seen_reg <= payload_seen_next;
        end
    end

`ifndef SYNTHESIS
    a_raw_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        raw_count_reg != 2'd3)
        else $error("Held byte count exceeds two.");

    a_pair_starts_with_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        emit.cnt == 2'd2 |-> emit.r0.out_kind == KIND_PAYLOAD && !emit.r0.last_of_run)
        else $error("A two-result byte must start with a payload result.");
`endif

endmodule

@@ src/slipdx_out_fifo.sv @@
// Three-entry result queue for the SLIP deframer; the head entry drives the output.
// Takes up to two results per cycle. Uses slipdx_pkg.
module slipdx_out_fifo (
    input  logic                aclk,
    input  logic                aresetn,
    input  slipdx_pkg::emit_t   emit,
    output logic                space_ok,
    output logic                head_valid,
    input  logic                head_ready,
    output slipdx_pkg::result_t head
);
    import slipdx_pkg::*;

    localparam int unsigned DEPTH = 3;

    result_t    entry_reg [DEPTH];
    result_t    entry_next [DEPTH];
    logic [1:0] count_reg, count_next;
    logic [1:0] count_after_pop;
    logic       pop;

    assign pop             = head_valid && head_ready;
    assign count_after_pop = count_reg - {1'b0, pop};
    assign space_ok        = (count_reg <= 2'd1);
    assign head_valid      = (count_reg != 2'd0);
    assign head            = entry_reg[0];

    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            entry_next[i] = entry_reg[i];
        end
        if (pop) begin
            entry_next[0] = entry_reg[1];
            entry_next[1] = entry_reg[2];
        end
        if (emit.cnt != 2'd0 && count_after_pop != 2'd3) begin
            entry_next[count_after_pop] = emit.r0;
        end
        if (emit.cnt == 2'd2 && count_after_pop <= 2'd1) begin
            entry_next[count_after_pop + 2'd1] = emit.r1;
        end
        count_next = count_after_pop + emit.cnt;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < DEPTH; i++) begin
            entry_reg[i] <= entry_next[i];
        end
    end

`ifndef SYNTHESIS
    a_push_needs_space: assert property (@(posedge aclk) disable iff (!aresetn)
        emit.cnt != 2'd0 |-> count_reg <= 2'd1)
        else $error("Results pushed into a full queue.");

    a_pair_count: assert property (@(posedge aclk) disable iff (!aresetn)
        emit.cnt == 2'd2 && !pop |=> count_reg == $past(count_reg) + 2'd2)
        else $error("Two pushed results not both stored.");

    a_single_last: assert property (@(posedge aclk) disable iff (!aresetn)
        emit.cnt == 2'd1 |-> emit.r0.last_of_run)
        else $error("A single result must close its run.");
`endif

endmodule

@@ src/slip_deframer_xor_check_core.sv @@
// Top level of the SLIP deframer with nibble XOR check.
// Instantiates slipdx_deframer and slipdx_out_fifo. Uses slipdx_pkg.
//
// The block takes one raw line byte per cycle on the slave side and emits unescaped payload
// bytes two line bytes late, followed by a frame end marker that reports a good or bad
// checksum when the frame carried payload. Every accepted byte is decoded in the same cycle
// from the registered frame state, and its zero, one or two results go into a three-entry
// result queue whose head drives the master side. s_tready is high while at most one result
// waits in that queue, so with a free-running sink one byte is accepted every cycle; a byte
// that yields two results (a literal escape byte followed by ordinary data, or a closing flag
// after a pending escape) can drop s_tready and stall the next byte.
module slip_deframer_xor_check_core (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] line_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic [1:0] m_tuser,   // [1:0] out_kind
    output logic       m_tlast
);
    import slipdx_pkg::*;

    emit_t   emit;
    result_t head;
    logic    accept;

    assign accept = s_tvalid && s_tready;

    slipdx_deframer u_deframer (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .line_byte (s_tdata),
        .emit      (emit)
    );

    slipdx_out_fifo u_out_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .emit       (emit),
        .space_ok   (s_tready),
        .head_valid (m_tvalid),
        .head_ready (m_tready),
        .head       (head)
    );

    assign m_tdata = head.out_byte;
    assign m_tuser = head.out_kind;
    assign m_tlast = head.last_of_run;

endmodule

@@ dv/slipdx_result_checker.sv @@
// Result checker for the SLIP deframer with nibble XOR check.
// Watches both stream channels, predicts the decoded results and compares them.
// Depends on slipdx_pkg.
module slipdx_result_checker (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    input  logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] line_byte
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata,   // [7:0] out_byte
    input  logic [1:0] m_tuser,   // [1:0] out_kind
    input  logic       m_tlast,
    output int         mismatches,
    output int         outstanding
);
    import slipdx_pkg::*;

    logic       in_frame;
    logic [1:0] held_cnt;
    logic [7:0] held [2];
    logic [7:0] running_xor;
    logic       esc_wait;
    logic       payload_emitted;

    result_t expected_results [$];
    result_t step_results [$];

    task automatic clear_frame();
        held_cnt        = 2'd0;
        held[0]         = 8'h00;
        held[1]         = 8'h00;
        running_xor     = 8'h00;
        esc_wait        = 1'b0;
        payload_emitted = 1'b0;
    endtask

    task automatic note_result(input logic [7:0] b, input kind_t k);
        result_t r;
        r.out_byte    = b;
        r.out_kind    = k;
        r.last_of_run = 1'b0;
        step_results = {step_results, r};
        if (k == KIND_PAYLOAD) begin
            payload_emitted = 1'b1;
        end
    endtask

    // Decodes one accepted line byte and queues the results it causes.
    task automatic decode_line_byte(input logic [7:0] b);
        logic [7:0] oldest;
        logic [7:0] sum_field;
        step_results.delete();
        if (!in_frame) begin
            if (b == FLAG_BYTE) begin
                in_frame = 1'b1;
                clear_frame();
            end
        end else if (b == FLAG_BYTE) begin
            if (held_cnt == 2'd2) begin
                sum_field = {held[0][3:0], 4'h0} + held[1];
                if (esc_wait) begin
                    note_result(ESC_BYTE, KIND_PAYLOAD);
                end
                if (payload_emitted) begin
                    note_result(8'h00, (sum_field == running_xor) ? KIND_END_GOOD
                                                                    : KIND_END_BAD);
                end
                in_frame = 1'b0;
            end else if (held_cnt == 2'd1) begin
                in_frame = 1'b0;
            end
            clear_frame();
        end else if (held_cnt < 2'd2) begin
            held[held_cnt[0]] = b;
            held_cnt          = held_cnt + 2'd1;
        end else begin
            oldest      = held[0];
            held[0]     = held[1];
            held[1]     = b;
            running_xor = running_xor ^ oldest;
            if (esc_wait) begin
                esc_wait = 1'b0;
                if (oldest == ESC_FLAG) begin
                    note_result(FLAG_BYTE, KIND_PAYLOAD);
                end else if (oldest == ESC_ESC) begin
                    note_result(ESC_BYTE, KIND_PAYLOAD);
                end else begin
                    note_result(ESC_BYTE, KIND_PAYLOAD);
                    if (oldest == ESC_BYTE) begin
                        esc_wait = 1'b1;
                    end else begin
                        note_result(oldest, KIND_PAYLOAD);
                    end
                end
            end else if (oldest == ESC_BYTE) begin
                esc_wait = 1'b1;
            end else begin
                note_result(oldest, KIND_PAYLOAD);
            end
        end
        if (step_results.size() > 0) begin
            step_results[step_results.size() - 1].last_of_run = 1'b1;
        end
        expected_results = {expected_results, step_results};
    endtask

    always @(posedge aclk) begin
        result_t want;
        if (!aresetn) begin
            in_frame = 1'b0;
            clear_frame();
            expected_results.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: expected no transaction, got byte %h kind %0d last %b",
                             $time, m_tdata, m_tuser, m_tlast);
                    mismatches = mismatches + 1;
                end else begin
                    want = expected_results[0];
                    expected_results.delete(0);
                    if (m_tdata !== want.out_byte || m_tuser !== want.out_kind ||
                        m_tlast !== want.last_of_run) begin
                        $display("%0t: expected %h/%0d/%b, got %h/%0d/%b (byte/kind/last)",
                                 $time, want.out_byte, want.out_kind, want.last_of_run,
                                 m_tdata, m_tuser, m_tlast);
                        mismatches = mismatches + 1;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                decode_line_byte(s_tdata);
            end
        end
        outstanding = expected_results.size();
    end

endmodule

@@ dv/tb_slip_deframer_xor_check_core.sv @@
// Testbench top for slip_deframer_xor_check_core: drives line bytes, random
// frames and noise with random idling on both sides. Uses slipdx_pkg and
// slipdx_result_checker, which predicts and compares the results.
module tb_slip_deframer_xor_check_core;
    import slipdx_pkg::*;

    localparam int TARGET_ITEMS = 1950;
    localparam int CALM_ITEMS   = 1700;
    localparam int CYCLE_LIMIT  = 400000;

    logic       aclk;
    logic       aresetn;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic [1:0] m_tuser;
    logic       m_tlast;

    int         mismatches;
    int         outstanding;
    int         items_sent;
    int         cycles;
    int         ready_hold;
    bit         calm;
    logic [7:0] frame_q [$];

    slip_deframer_xor_check_core u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    slipdx_result_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always begin
        aclk = 1'b0;
        #1;
        aclk = 1'b1;
        #1;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // The sink drops m_tready in random stall bursts until the calm part of the run.
    always @(negedge aclk) begin
        if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
            m_tready   <= 1'b0;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
            ready_hold <= $urandom_range(0, 16);
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic send_byte(input logic [7:0] b, input bit counted);
        if (!calm && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        if (counted) begin
            items_sent++;
            calm = (items_sent >= CALM_ITEMS);
        end
    endtask

    function automatic logic [7:0] any_but_flag();
        logic [7:0] r;
        do r = 8'($urandom); while (r == FLAG_BYTE);
        return r;
    endfunction

    // Sends flag, the raw bytes in frame_q, two checksum nibbles and the closing flag.
    // The high nibble byte carries random upper bits that the wrapped sum ignores; the low one's are offset in it.
    task automatic send_frame_q(input bit bad);
        logic [7:0] x;
        logic [7:0] lo;
        logic [7:0] hi;
        logic [7:0] d;
        x = 8'h00;
        foreach (frame_q[i]) begin
            x = x ^ frame_q[i];
        end
        if (bad) begin
            x = x ^ 8'($urandom_range(1, 255));
        end
        do lo = {4'($urandom), x[3:0]}; while (lo == FLAG_BYTE);
        d = x - lo;
        do hi = {4'($urandom), d[7:4]}; while (hi == FLAG_BYTE);
        send_byte(FLAG_BYTE, 1'b1);
        foreach (frame_q[i]) begin
            send_byte(frame_q[i], 1'b1);
        end
        send_byte(hi, 1'b1);
        send_byte(lo, 1'b1);
        send_byte(FLAG_BYTE, 1'b1);
    endtask

    task automatic build_random_content(input int len);
        frame_q.delete();
        while (frame_q.size() < len) begin
            case ($urandom_range(0, 9))
                6: begin
                    frame_q = {frame_q, ESC_BYTE, ESC_FLAG};
                end
                7: begin
                    frame_q = {frame_q, ESC_BYTE, ESC_ESC};
                end
                8: frame_q = {frame_q, ESC_BYTE};
                9: frame_q = {frame_q, $urandom_range(0, 1) ? ESC_FLAG : ESC_ESC};
                default: frame_q = {frame_q, any_but_flag()};
            endcase
        end
    endtask

    initial begin
        int len;
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = 8'h00;
        items_sent = 0;
        calm       = 1'b0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Bytes outside a frame are ignored.
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        // Two adjacent flags, every escape form, a DB pair and a trailing DB.
        send_byte(FLAG_BYTE, 1'b1);
        frame_q = {ESC_BYTE, ESC_FLAG, ESC_BYTE, ESC_ESC, ESC_BYTE, ESC_BYTE,
                   8'h00, 8'hFF, ESC_BYTE};
        send_frame_q(1'b0);
        // One byte between flags drops the frame and goes back to hunting.
        send_byte(FLAG_BYTE, 1'b1);
        send_byte(8'h55, 1'b1);
        send_byte(FLAG_BYTE, 1'b1);
        send_byte(8'h12, 1'b1);
        // Empty content with two nibbles, then a bad checksum.
        frame_q.delete();
        send_frame_q(1'b0);
        frame_q = {8'h7F, 8'h80};
        send_frame_q(1'b1);

        while (items_sent < TARGET_ITEMS) begin
            case ($urandom_range(0, 19)) inside
                [14:15]: begin
                    build_random_content($urandom_range(0, 12));
                    send_frame_q(1'b1);
                end
                16: begin
                    repeat ($urandom_range(1, 3)) send_byte(any_but_flag(), 1'b0);
                end
                17: begin
                    send_byte(FLAG_BYTE, 1'b1);
                    send_byte(any_but_flag(), 1'b1);
                    send_byte(FLAG_BYTE, 1'b1);
                end
                18: begin
                    send_byte(FLAG_BYTE, 1'b1);
                    build_random_content($urandom_range(0, 12));
                    send_frame_q($urandom_range(0, 3) == 0);
                end
                19: begin
                    frame_q.delete();
                    send_frame_q(1'($urandom_range(0, 1)));
                end
                default: begin
                    len = ($urandom_range(0, 15) == 0) ? $urandom_range(13, 60)
                                                       : $urandom_range(1, 12);
                    build_random_content(len);
                    send_frame_q(1'b0);
                end
            endcase
        end
        s_tvalid <= 1'b0;

        while (outstanding != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
